@@ hw/rtl/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the chat color code stripper
// Result beat layout, the load bundle between the scanner and the output
// queue, and the character codes used by the scanner.
// ----------------------------------------------------------------------------
package ccs_pkg;

  // Character codes
  localparam logic [7:0] ColorIntro = 8'd3;
  localparam logic [7:0] CommaChar  = 8'd44;
  localparam logic [7:0] BoldCode   = 8'd2;
  localparam logic [7:0] PlainCode  = 8'd15;
  localparam logic [7:0] RevCode    = 8'd22;
  localparam logic [7:0] UlineCode  = 8'd31;
  localparam logic [7:0] DigitLo    = 8'd48;
  localparam logic [7:0] DigitHi    = 8'd57;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       stripped;
  } res_t;

  // Results of one input beat, handed to the output queue
  typedef struct packed {
    logic       fire;
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } load_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= DigitLo) && (b <= DigitHi);
  endfunction

  function automatic logic is_format(input logic [7:0] b);
    return (b == BoldCode) || (b == PlainCode) || (b == RevCode) || (b == UlineCode);
  endfunction

endpackage

@@ hw/rtl/ccs_scan.sv @@
// ----------------------------------------------------------------------------
// ccs_scan: input register and code scanner
// Holds one input beat, and when the output queue has room decodes it
// against the scan phase, producing up to two result beats.
// ----------------------------------------------------------------------------
module ccs_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          room,
  output ccs_pkg::load_t load
);
  import ccs_pkg::*;

  localparam logic [2:0] PhText  = 3'd0;
  localparam logic [2:0] PhIntro = 3'd1;
  localparam logic [2:0] PhFg1   = 3'd2;
  localparam logic [2:0] PhFg2   = 3'd3;
  localparam logic [2:0] PhComma = 3'd4;
  localparam logic [2:0] PhBg1   = 3'd5;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic [2:0] phase;
  logic       removed;

  logic [2:0] phase_next;
  logic       removed_next;
  logic       go_text;
  logic       comma_out;
  logic       byte_out;
  logic       tail_comma;
  logic       dig;
  logic       fire;

  assign fire     = hold_valid && room;
  assign in_ready = !hold_valid || fire;
  assign dig      = is_digit(hold_byte);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

  // Phase decode
  always_comb begin
    phase_next   = phase;
    removed_next = removed;
    go_text      = 1'b0;
    comma_out    = 1'b0;
    byte_out     = 1'b0;
    unique case (phase)
      PhIntro: begin
        if (dig) begin
          phase_next   = PhFg1;
          removed_next = 1'b1;
        end else begin
          go_text = 1'b1;
        end
      end
      PhFg1: begin
        if (dig) begin
          phase_next   = PhFg2;
          removed_next = 1'b1;
        end else begin
          go_text = 1'b1;
        end
      end
      PhFg2: begin
        if (hold_byte == CommaChar) begin
          phase_next = PhComma;
        end else begin
          go_text = 1'b1;
        end
      end
      PhComma: begin
        if (dig) begin
          phase_next   = PhBg1;
          removed_next = 1'b1;
        end else begin
          comma_out = 1'b1;
          go_text   = 1'b1;
        end
      end
      PhBg1: begin
        if (dig) begin
          phase_next   = PhText;
          removed_next = 1'b1;
        end else begin
          go_text = 1'b1;
        end
      end
      default: go_text = 1'b1;
    endcase
    // plain text handling
    if (go_text) begin
      phase_next = PhText;
      if (hold_byte == ColorIntro) begin
        phase_next   = PhIntro;
        removed_next = 1'b1;
      end else if (is_format(hold_byte)) begin
        removed_next = 1'b1;
      end else begin
        byte_out = 1'b1;
      end
    end
  end

  // held comma at end of string is kept
  assign tail_comma = hold_last && (phase_next == PhComma);

  // Result assembly
  always_comb begin
    load.fire  = fire;
    load.r0    = '0;
    load.r1    = '0;
    load.count = 2'd0;
    if (comma_out) begin
      load.r0.data  = CommaChar;
      load.r0.valid = 1'b1;
      load.count    = 2'd1;
      if (byte_out) begin
        load.r1.data  = hold_byte;
        load.r1.valid = 1'b1;
        load.count    = 2'd2;
      end
    end else if (byte_out) begin
      load.r0.data  = hold_byte;
      load.r0.valid = 1'b1;
      load.count    = 2'd1;
    end else if (tail_comma) begin
      load.r0.data  = CommaChar;
      load.r0.valid = 1'b1;
      load.count    = 2'd1;
    end
    // end marker goes on the final beat
    if (hold_last) begin
      if (load.count == 2'd2) begin
        load.r1.last     = 1'b1;
        load.r1.stripped = removed_next;
      end else begin
        load.count       = 2'd1;
        load.r0.last     = 1'b1;
        load.r0.stripped = removed_next;
      end
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PhText;
      removed <= 1'b0;
    end else if (fire) begin
      if (hold_last) begin
        phase   <= PhText;
        removed <= 1'b0;
      end else begin
        phase   <= phase_next;
        removed <= removed_next;
      end
    end
  end

endmodule

@@ hw/rtl/ccs_out_buf.sv @@
// ----------------------------------------------------------------------------
// ccs_out_buf: two-entry result queue
// Takes the one or two result beats of an input beat at once and hands
// them out one per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module ccs_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  ccs_pkg::load_t load,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output ccs_pkg::res_t  head
);
  import ccs_pkg::*;

  logic [1:0] cnt;
  res_t       slot0;
  res_t       slot1;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign room      = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign head      = slot0;

  // Queue update: a load only lands when the queue is empty or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load.fire) begin
      cnt <= load.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
    if (load.fire) begin
      slot0 <= load.r0;
      slot1 <= load.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

@@ hw/rtl/chat_color_code_stripper.sv @@
// Path: an accepted input beat is held in the input register, then loaded into the result queue.
// Throughput: one input beat per cycle while the output is taken every cycle;
// an input beat that yields two result beats (a released comma plus a byte)
// holds off the next input beat until the two-entry result queue is down to one entry.
// Reset: synchronous, active high; clears the queue, input register and scan
// phase to plain text with the removed flag cleared.
// ----------------------------------------------------------------------------
// chat_color_code_stripper: top level
// Strips chat formatting and color codes from a byte stream and flags on the
// final beat whether anything was removed.
// ----------------------------------------------------------------------------
module chat_color_code_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  output logic       stripped_any
);
  import ccs_pkg::*;

  load_t load;
  res_t  head;
  logic  room;

  ccs_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .room     (room),
    .load     (load)
  );

  ccs_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result fields
  assign out_byte     = head.data;
  assign byte_valid   = head.valid;
  assign out_last     = head.last;
  assign stripped_any = head.stripped;

endmodule

@@ hw/rtl/ccs_checker.sv @@
// ----------------------------------------------------------------------------
// ccs_props: port-level checks for the chat color code stripper
// Watches the top level ports and flags protocol or framing slips.
// ----------------------------------------------------------------------------
module ccs_props (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       out_last,
  input logic       stripped_any
);

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result beat changed");

  // Empty beat only as the end marker, with zero data
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_last && (out_byte == 8'd0))
    else $error("empty beat not a clean end marker");

  // Stripped flag only on the final beat
  a_strip_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stripped_any |-> out_last)
    else $error("stripped_any set before end of string");

endmodule

bind chat_color_code_stripper ccs_props u_ccs_props (.*);

@@ bench/ccs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_checker: result predictor and scoreboard for the color code stripper
// Watches both channels. Every accepted input beat runs through a local model
// of the code scanner, which queues the beats the block must produce. Every
// accepted output beat is compared against the oldest queued beat.
// ----------------------------------------------------------------------------
module ccs_checker
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       byte_valid,
  input  logic       out_last,
  input  logic       stripped_any,
  output int         fail_count,
  output int         pending
);

  typedef enum logic [2:0] {
    ScanText, ScanIntro, ScanFg1, ScanFg2, ScanComma, ScanBg1
  } scan_t;

  scan_t scan;
  logic  removed;
  res_t  kept_q[$];
  res_t  want;
  int    errs;

  function automatic logic numeral(input logic [7:0] b);
    return b >= DigitLo && b <= DigitHi;
  endfunction

  function automatic res_t kept(input logic [7:0] b);
    res_t r;
    r.data     = b;
    r.valid    = 1'b1;
    r.last     = 1'b0;
    r.stripped = 1'b0;
    return r;
  endfunction

  // Scanner model: one input beat in, zero to two result beats queued
  task automatic strip_codes(input logic [7:0] b, input logic fin);
    res_t beats[$];
    res_t tail_beat;
    logic plain;
    plain = 1'b1;
    case (scan)
      ScanIntro: if (numeral(b)) begin
        scan = ScanFg1; removed = 1'b1; plain = 1'b0;
      end
      ScanFg1: if (numeral(b)) begin
        scan = ScanFg2; removed = 1'b1; plain = 1'b0;
      end
      ScanFg2: if (b == CommaChar) begin
        scan = ScanComma; plain = 1'b0;
      end
      ScanComma: begin
        if (numeral(b)) begin
          scan = ScanBg1; removed = 1'b1; plain = 1'b0;
        end else begin
          // held comma was not a background separator after all
          beats.push_back(kept(CommaChar));
        end
      end
      ScanBg1: if (numeral(b)) begin
        scan = ScanText; removed = 1'b1; plain = 1'b0;
      end
      default: ;
    endcase

    // byte not consumed by a color code: scan it as text
    if (plain) begin
      scan = ScanText;
      if (b == ColorIntro) begin
        scan = ScanIntro;
        removed = 1'b1;
      end else if (b == BoldCode || b == PlainCode || b == RevCode || b == UlineCode) begin
        removed = 1'b1;
      end else begin
        beats.push_back(kept(b));
      end
    end

    // end of string: flush a held comma, tag the final beat
    if (fin) begin
      if (scan == ScanComma) beats.push_back(kept(CommaChar));
      if (beats.size() == 0) beats.push_back('0);
      tail_beat = beats[beats.size()-1];
      tail_beat.last = 1'b1;
      tail_beat.stripped = removed;
      beats[beats.size()-1] = tail_beat;
      scan = ScanText;
      removed = 1'b0;
    end

    foreach (beats[i]) kept_q.push_back(beats[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan = ScanText;
      removed = 1'b0;
      kept_q.delete();
      errs = 0;
    end else begin
      if (in_valid && in_ready) strip_codes(in_byte, in_last);

      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected beat: expected none, actual byte %h valid %b last %b strip %b",
                   $time, out_byte, byte_valid, out_last, stripped_any);
        end else begin
          want = kept_q.pop_front();
          // data only matters on a beat that carries a byte
          if (byte_valid !== want.valid || (want.valid && out_byte !== want.data) ||
              out_last !== want.last || stripped_any !== want.stripped) begin
            errs++;
            $display("%0t: mismatch: expected byte %h valid %b last %b strip %b",
                     $time, want.data, want.valid, want.last, want.stripped);
            $display("%0t:           actual   byte %h valid %b last %b strip %b",
                     $time, out_byte, byte_valid, out_last, stripped_any);
          end
        end
      end
    end
    pending    <= kept_q.size();
    fail_count <= errs;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the chat color code stripper
// Sends directed strings covering every code and corner case, then random
// strings built mostly from well-formed color and format codes mixed with
// text and noise, under several sender idle and receiver stall mixes. The
// checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import ccs_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int PhaseBeats  = 450;
  localparam int DirCount    = 25;

  // directed beats: {last, byte}
  localparam logic [8:0] DirBeats [DirCount] = '{
    {1'b1, 8'h41},
    {1'b0, 8'h00}, {1'b1, 8'hFF},
    {1'b0, BoldCode}, {1'b0, PlainCode}, {1'b0, RevCode}, {1'b1, UlineCode},
    {1'b0, ColorIntro}, {1'b0, 8'h31}, {1'b0, 8'h32}, {1'b0, CommaChar},
    {1'b0, 8'h33}, {1'b0, 8'h34}, {1'b1, 8'h78},
    {1'b0, ColorIntro}, {1'b0, 8'h30}, {1'b0, 8'h39}, {1'b1, CommaChar},
    {1'b0, ColorIntro}, {1'b0, 8'h35}, {1'b0, 8'h36}, {1'b0, CommaChar},
    {1'b0, 8'h61}, {1'b0, ColorIntro}, {1'b1, 8'h2F}
  };

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = '0;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic       stripped_any;
  int         fail_count;
  int         pending;

  int         idle_pct  = 0;
  int         stall_pct = 0;
  int         idle_cycles = 0;
  int         sent;
  logic [7:0] msg_q[$];

  chat_color_code_stripper u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .out_last    (out_last),
    .stripped_any(stripped_any)
  );

  ccs_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .out_last    (out_last),
    .stripped_any(stripped_any),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat; valid drops only across an idle gap
  task automatic send_beat(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic [7:0] digit_char();
    return DigitLo + 8'($urandom_range(9));
  endfunction

  // random string: mostly color and format codes with text, some noise
  task automatic build_message();
    int ntok;
    int nfg;
    int nbg;
    msg_q.delete();
    ntok = $urandom_range(1, 8);
    repeat (ntok) begin
      case ($urandom_range(9))
        0, 1, 2: msg_q.push_back(8'($urandom_range(1, 255)));
        3: begin
          case ($urandom_range(3))
            0: msg_q.push_back(BoldCode);
            1: msg_q.push_back(PlainCode);
            2: msg_q.push_back(RevCode);
            default: msg_q.push_back(UlineCode);
          endcase
        end
        4, 5, 6, 7: begin
          msg_q.push_back(ColorIntro);
          nfg = $urandom_range(2);
          repeat (nfg) msg_q.push_back(digit_char());
          if ($urandom_range(3) != 0) begin
            msg_q.push_back(CommaChar);
            nbg = $urandom_range(2);
            repeat (nbg) msg_q.push_back(digit_char());
          end
        end
        8: msg_q.push_back(CommaChar);
        default: msg_q.push_back(digit_char());
      endcase
    end
  endtask

  initial begin
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings, no idling
    for (int i = 0; i < DirCount; i++) send_beat(DirBeats[i][7:0], DirBeats[i][8]);

    // random strings across the idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      sent = 0;
      while (sent < PhaseBeats) begin
        build_message();
        foreach (msg_q[i]) send_beat(msg_q[i], i == msg_q.size() - 1);
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    // drain outstanding results, then allow for latency
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
